// ----- hdl/cdq_pkg.sv -----
// Shared types, constants and ring-index helpers for the circular deque.
// Used by cdq_ctrl, cdq_dpath and circular_deque. No dependencies.
`default_nettype none

package cdq_pkg;

   localparam int DEPTH   = 16;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FUNC_W  = 3;
   localparam int WORD_W  = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [FUNC_W-1:0] FN_INS_FRONT  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INS_REAR   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DEL_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_DEL_REAR   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd4;
   localparam logic [FUNC_W-1:0] FN_PEEK_REAR  = 3'd5;

   localparam logic [WORD_W-1:0] WORD_MISS = '1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;   // latch the accepted beat
      logic exec;      // run the operation against the ring
      logic load;      // move the result into the output register
   } cmd_type;

   // Clamp a written capacity into 1..DEPTH.
   function automatic logic [CNT_W-1:0] clip_cap(input logic [CAP_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) begin
         return CNT_W'(1);
      end else if (w > 32'(DEPTH)) begin
         return CNT_W'(DEPTH);
      end else begin
         return CNT_W'(w);
      end
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] pe;
      pe = (CNT_W + 1)'(p) + (CNT_W + 1)'(1);
      if (pe >= (CNT_W + 1)'(cap)) begin
         return '0;
      end else begin
         return PTR_W'(pe);
      end
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] pe;
      pe = (CNT_W + 1)'(p);
      if (pe == '0 || pe >= (CNT_W + 1)'(cap)) begin
         return PTR_W'(cap - CNT_W'(1));
      end else begin
         return PTR_W'(pe - (CNT_W + 1)'(1));
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/cdq_ctrl.sv -----
// Controller for the circular deque: sequences accept, execute and result load,
// and owns the result-valid flag. Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl
   import cdq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      cmd.capture = accept;
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.load    = (state_ff == ST_DONE) && (!out_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (cmd.load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/cdq_dpath.sv -----
// Datapath for the circular deque: ring memory, head/tail pointers, fill count,
// capacity register and the result register. Depends on cdq_pkg.
`default_nettype none

module cdq_dpath
   import cdq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [WORD_W-1:0] req_value,
   input  wire logic              csr_wen,
   input  wire logic [CAP_W-1:0]  csr_wdata,
   output logic                   rsp_success,
   output logic [WORD_W-1:0]      rsp_read_value,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full
);

   logic [WORD_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]  cap_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  cap_new;

   logic [FUNC_W-1:0] func_ff;
   logic [WORD_W-1:0] value_ff;
   logic [WORD_W-1:0] rdata_ff;
   logic              ok_ff, ok_in;
   logic              hit_ff, hit_in;
   logic              miss_ff, miss_in;
   logic              empty_ff, full_ff;

   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]  rd_addr;
   logic              is_empty_now, is_full_now;

   assign is_empty_now = (fill_ff == '0);
   assign is_full_now  = (fill_ff >= cap_ff);
   assign cap_new      = clip_cap(csr_wdata);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      ok_in   = 1'b0;
      hit_in  = 1'b0;
      miss_in = 1'b0;
      wr_en   = 1'b0;
      wr_addr = head_ff;
      rd_addr = head_ff;
      case (func_ff)
         FN_INS_FRONT: begin
            if (!is_full_now) begin
               head_in = ring_prev(head_ff, cap_ff);
               wr_en   = 1'b1;
               wr_addr = head_in;
               fill_in = fill_ff + CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         FN_INS_REAR: begin
            if (!is_full_now) begin
               tail_in = ring_next(tail_ff, cap_ff);
               wr_en   = 1'b1;
               wr_addr = tail_in;
               fill_in = fill_ff + CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         FN_DEL_FRONT: begin
            if (!is_empty_now) begin
               head_in = ring_next(head_ff, cap_ff);
               fill_in = fill_ff - CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         FN_DEL_REAR: begin
            if (!is_empty_now) begin
               tail_in = ring_prev(tail_ff, cap_ff);
               fill_in = fill_ff - CNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         FN_PEEK_FRONT: begin
            rd_addr = head_ff;
            ok_in   = !is_empty_now;
            hit_in  = !is_empty_now;
            miss_in = is_empty_now;
         end
         FN_PEEK_REAR: begin
            rd_addr = tail_ff;
            ok_in   = !is_empty_now;
            hit_in  = !is_empty_now;
            miss_in = is_empty_now;
         end
         default: begin
         end
      endcase
   end

   // pointer and count state; a capacity write empties the ring
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= clip_cap(CAP_RESET);
         head_ff <= '0;
         tail_ff <= PTR_W'(clip_cap(CAP_RESET) - CNT_W'(1));
         fill_ff <= '0;
      end else if (csr_wen) begin
         cap_ff  <= cap_new;
         head_ff <= '0;
         tail_ff <= PTR_W'(cap_new - CNT_W'(1));
         fill_ff <= '0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) mem[wr_addr] <= value_ff;
      if (cmd.exec) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         ok_ff    <= ok_in;
         hit_ff   <= hit_in;
         miss_ff  <= miss_in;
         empty_ff <= (fill_in == '0);
         full_ff  <= (fill_in >= cap_ff);
      end
      if (cmd.load) begin
         rsp_success    <= ok_ff;
         rsp_read_value <= hit_ff ? rdata_ff : (miss_ff ? WORD_MISS : '0);
         rsp_is_empty   <= empty_ff;
         rsp_is_full    <= full_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/circular_deque.sv -----
// Circular deque top level: stream channels around the controller and datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_dpath.
//
// Usage:
//   req_*  input stream; each beat carries one operation code and a word.
//   rsp_*  result stream; exactly one beat per request beat, in order.
//   csr_*  capacity register (1..16, 0 reads as 1, larger clamps to 16);
//          a write also empties the deque. Write only while the block is idle.
// Timing:
//   A request is taken in the idle state, executed against the ring memory
//   on the next cycle, and its result moved into the output register in the
//   done state once that register is free. One request is in flight at a
//   time: a new request is taken only after the previous result has been
//   loaded into the output register.
// Reset: head pointer and fill count clear, capacity returns to 16, the tail
//   sits at capacity minus one. Memory contents are not cleared.
// Stall: while rsp_tready is low the result is held; the next request can be
//   taken and executed, and waits in the datapath until the output frees.
`default_nettype none

module circular_deque
   import cdq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [2:0] func, [34:3] value, [39:35] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [0] success, [32:1] read_value,
                                         // [33] is_empty, [34] is_full, [39:35] zero
   input  wire logic        csr_wen,
   input  wire logic [4:0]  csr_wdata
);

   cmd_type           cmd;
   logic              success;
   logic [WORD_W-1:0] read_value;
   logic              is_empty;
   logic              is_full;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cdq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_tdata[2:0]),
      .req_value      (req_tdata[34:3]),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .rsp_success    (success),
      .rsp_read_value (read_value),
      .rsp_is_empty   (is_empty),
      .rsp_is_full    (is_full)
   );

   assign rsp_tdata = {5'b0, is_full, is_empty, read_value, success};

endmodule

`default_nettype wire
